// ===== rtl/core/mfd_pkg.sv =====
// Package for the modulated feedback delay: sizes, codes, command/status types
// and the quarter-wave sine table builder. No dependencies.
package mfd_pkg;

    localparam int STORE_DEPTH     = 131072;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int POS_W           = ADDR_W + 8;
    localparam int SINE_TABLE_SIZE = 1024;
    localparam int SINE_BITS       = $clog2(SINE_TABLE_SIZE);
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [15:0] GAIN_UNITY = 16'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 3'd0,
        REG_DEPTH    = 3'd1,
        REG_STEP     = 3'd2,
        REG_WET      = 3'd3,
        REG_FEEDBACK = 3'd4,
        REG_DRY      = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SINE,
        ST_MUL,
        ST_ADDR,
        ST_INTERP,
        ST_MIX,
        ST_OUT
    } mfd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rom_rd;
        logic mul;
        logic mem_rd;
        logic interp;
        logic mix;
        logic finish;
    } mfd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } mfd_status_t;

    typedef logic [15:0] sine_rom_t [0:SINE_TABLE_SIZE];

    // Q30 odd polynomial for sin(pi/2 * x), rounded to Q15 and clamped
    function automatic sine_rom_t build_sine();
        sine_rom_t rom;
        longint    x;
        longint    x2;
        longint    acc;
        longint    v;
        for (int i = 0; i <= SINE_TABLE_SIZE; i++)
        begin
            x   = (longint'(i) * 64'sd1073741824) / SINE_TABLE_SIZE;
            x2  = (x * x) >>> 30;
            acc = 64'sd172272;
            acc = -64'sd5026995 + ((acc * x2) >>> 30);
            acc = 64'sd85569304 + ((acc * x2) >>> 30);
            acc = -64'sd693598668 + ((acc * x2) >>> 30);
            acc = 64'sd1686629713 + ((acc * x2) >>> 30);
            v   = (((acc * x) >>> 30) + 64'sd16384) >>> 15;
            if (v < 0)
            begin
                v = 0;
            end
            if (v > 32768)
            begin
                v = 32768;
            end
            rom[i] = v[15:0];
        end
        return rom;
    endfunction

endpackage

// ===== rtl/core/mfd_if.sv =====
// Stream interfaces for input and result words of the modulated delay.
// Depends on nothing.
interface mfd_in_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface mfd_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ===== rtl/core/mfd_ctrl.sv =====
// Sequencer for the modulated delay: steps one word through the datapath.
// Depends on mfd_pkg.
module mfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mfd_pkg::mfd_status_t status,
    output mfd_pkg::mfd_cmd_t    cmd
);

    mfd_pkg::mfd_state_t state_reg;
    mfd_pkg::mfd_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mfd_pkg::ST_IDLE:   if (in_valid) state_next = mfd_pkg::ST_SINE;
            mfd_pkg::ST_SINE:   state_next = mfd_pkg::ST_MUL;
            mfd_pkg::ST_MUL:    state_next = mfd_pkg::ST_ADDR;
            mfd_pkg::ST_ADDR:   state_next = mfd_pkg::ST_INTERP;
            mfd_pkg::ST_INTERP: state_next = mfd_pkg::ST_MIX;
            mfd_pkg::ST_MIX:    state_next = mfd_pkg::ST_OUT;
            mfd_pkg::ST_OUT:    if (!status.out_busy) state_next = mfd_pkg::ST_IDLE;
            default:            state_next = mfd_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            mfd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            mfd_pkg::ST_SINE:   cmd.rom_rd = 1'b1;
            mfd_pkg::ST_MUL:    cmd.mul    = 1'b1;
            mfd_pkg::ST_ADDR:   cmd.mem_rd = 1'b1;
            mfd_pkg::ST_INTERP: cmd.interp = 1'b1;
            mfd_pkg::ST_MIX:    cmd.mix    = 1'b1;
            mfd_pkg::ST_OUT:    cmd.finish = !status.out_busy;
            default:            cmd        = '0;
        endcase
    end

endmodule

// ===== rtl/core/mfd_datapath.sv =====
// Datapath of the modulated delay: config registers, LFO, sine ROM, delay
// stores, interpolation, feedback and output mix. Depends on mfd_pkg.
module mfd_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  mfd_pkg::mfd_cmd_t                    cmd,
    output mfd_pkg::mfd_status_t                 status,
    input  logic signed [15:0]                   left_in,
    input  logic signed [15:0]                   right_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [15:0]                   left_out,
    output logic signed [15:0]                   right_out
);

    localparam int AW = mfd_pkg::ADDR_W;
    localparam int PW = mfd_pkg::POS_W;
    localparam int SB = mfd_pkg::SINE_BITS;
    localparam mfd_pkg::sine_rom_t SINE_ROM = mfd_pkg::build_sine();

    // configuration
    logic [AW-1:0] delay_reg;
    logic [AW-1:0] depth_reg;
    logic [31:0]   step_reg;
    logic [15:0]   wet_reg;
    logic [15:0]   fb_reg;
    logic [15:0]   dry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
            depth_reg <= '0;
            step_reg  <= '0;
            wet_reg   <= '0;
            fb_reg    <= '0;
            dry_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfd_pkg::REG_DELAY:    delay_reg <= cfg_data[AW-1:0];
                mfd_pkg::REG_DEPTH:    depth_reg <= cfg_data[AW-1:0];
                mfd_pkg::REG_STEP:     step_reg  <= cfg_data[31:0];
                mfd_pkg::REG_WET:      wet_reg   <= cfg_data[15:0];
                mfd_pkg::REG_FEEDBACK: fb_reg    <= cfg_data[15:0];
                mfd_pkg::REG_DRY:      dry_reg   <= cfg_data[15:0];
                default:               ;
            endcase
        end
    end

    // saturated gains and clamped depth
    logic [15:0] wet_g, fb_g, dry_g;
    logic [AW-1:0] depth_c;
    assign wet_g   = (wet_reg > mfd_pkg::GAIN_UNITY) ? mfd_pkg::GAIN_UNITY : wet_reg;
    assign fb_g    = (fb_reg  > mfd_pkg::GAIN_UNITY) ? mfd_pkg::GAIN_UNITY : fb_reg;
    assign dry_g   = (dry_reg > mfd_pkg::GAIN_UNITY) ? mfd_pkg::GAIN_UNITY : dry_reg;
    assign depth_c = (depth_reg > delay_reg) ? delay_reg : depth_reg;

    // write pointer, wrap flag and LFO phase
    logic [AW-1:0] wp_reg;
    logic          wrapped_reg;
    logic [31:0]   phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            phase_reg   <= '0;
        end
        else if (cmd.mix)
        begin
            wp_reg    <= wp_reg + 1'b1;
            phase_reg <= phase_reg + step_reg;
            if (wp_reg == {AW{1'b1}})
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // input latch
    logic signed [15:0] lin_reg, rin_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lin_reg <= left_in;
            rin_reg <= right_in;
        end
    end

    // sine ROM lookup; odd quadrants read the mirrored entry
    logic [SB-1:0] idx;
    logic [SB:0]   rom_addr;
    logic [15:0]   rom_q_reg;
    logic          neg_reg;
    assign idx      = phase_reg[29 -: SB];
    assign rom_addr = phase_reg[30] ? (SB+1)'(mfd_pkg::SINE_TABLE_SIZE) - {1'b0, idx}
                                    : {1'b0, idx};

    always_ff @(posedge clk)
    begin
        if (cmd.rom_rd)
        begin
            rom_q_reg <= SINE_ROM[rom_addr];
            neg_reg   <= phase_reg[31];
        end
    end

    // depth times sine
    logic signed [16:0] sine_s;
    logic signed [AW+17:0] num_reg;
    assign sine_s = neg_reg ? -$signed({1'b0, rom_q_reg}) : $signed({1'b0, rom_q_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            num_reg <= $signed({1'b0, depth_c}) * sine_s;
        end
    end

    // read position in Q8, modulo the store
    logic [PW-1:0] pos;
    logic [AW-1:0] addr_a, addr_b;
    logic [AW+17:0] num_sh;
    assign num_sh = num_reg >>> 7;
    assign pos    = {wp_reg, 8'd0} - {delay_reg, 8'd0} + num_sh[PW-1:0];
    assign addr_a = pos[PW-1:8];
    assign addr_b = addr_a + 1'b1;

    // delay stores
    logic signed [15:0] lmem [mfd_pkg::STORE_DEPTH];
    logic signed [15:0] rmem [mfd_pkg::STORE_DEPTH];
    logic signed [15:0] la_reg, lb_reg, ra_reg, rb_reg;
    logic [7:0] frac_reg;
    logic eq_a_reg, eq_b_reg, val_a_reg, val_b_reg;
    logic signed [15:0] lst_reg, rst_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            la_reg <= lmem[addr_a];
            lb_reg <= lmem[addr_b];
            ra_reg <= rmem[addr_a];
            rb_reg <= rmem[addr_b];
        end
    end

    // entry flags: current slot forwards the input, unwritten slots read zero
    always_ff @(posedge clk)
    begin
        if (cmd.mem_rd)
        begin
            frac_reg  <= pos[7:0];
            eq_a_reg  <= (addr_a == wp_reg);
            eq_b_reg  <= (addr_b == wp_reg);
            val_a_reg <= wrapped_reg || (addr_a <= wp_reg);
            val_b_reg <= wrapped_reg || (addr_b <= wp_reg);
        end
    end

    function automatic logic signed [15:0] pick(input logic eq, input logic val,
                                                 input logic signed [15:0] fwd,
                                                 input logic signed [15:0] mem);
        return eq ? fwd : (val ? mem : 16'sd0);
    endfunction

    function automatic logic signed [15:0] lerp(input logic signed [15:0] a,
                                                 input logic signed [15:0] b,
                                                 input logic [7:0] f);
        logic signed [9:0]  w0;
        logic signed [9:0]  w1;
        logic signed [26:0] acc;
        w0  = 10'sd256 - $signed({2'b00, f});
        w1  = $signed({2'b00, f});
        acc = 27'(a * w0) + 27'(b * w1) + 27'sd128;
        acc = acc >>> 8;
        return acc[15:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        if (v > 36'sd32767)
        begin
            return 16'sh7FFF;
        end
        else if (v < -36'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // interpolation
    logic signed [15:0] ldel_reg, rdel_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.interp)
        begin
            ldel_reg <= lerp(pick(eq_a_reg, val_a_reg, lin_reg, la_reg),
                             pick(eq_b_reg, val_b_reg, lin_reg, lb_reg), frac_reg);
            rdel_reg <= lerp(pick(eq_a_reg, val_a_reg, rin_reg, ra_reg),
                             pick(eq_b_reg, val_b_reg, rin_reg, rb_reg), frac_reg);
        end
    end

    // feedback into the stored sample
    function automatic logic signed [15:0] fb_mix(input logic signed [15:0] x,
                                                   input logic signed [15:0] d,
                                                   input logic [15:0] g);
        logic signed [35:0] p;
        p = 36'($signed({1'b0, g}) * d) + 36'sd16384;
        p = p >>> 15;
        return sat16(p + 36'(x));
    endfunction

    function automatic logic signed [15:0] lst_reg_next();
        return fb_mix(lin_reg, ldel_reg, fb_g);
    endfunction

    function automatic logic signed [15:0] rst_reg_next();
        return fb_mix(rin_reg, rdel_reg, fb_g);
    endfunction

    // store write-back at the write pointer
    always_ff @(posedge clk)
    begin
        if (cmd.mix)
        begin
            lmem[wp_reg] <= lst_reg_next();
            rmem[wp_reg] <= rst_reg_next();
        end
    end

    logic signed [33:0] lwet_reg, rwet_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.mix)
        begin
            lst_reg  <= lst_reg_next();
            rst_reg  <= rst_reg_next();
            lwet_reg <= 34'($signed({1'b0, wet_g}) * ldel_reg);
            rwet_reg <= 34'($signed({1'b0, wet_g}) * rdel_reg);
        end
    end

    // output mix
    function automatic logic signed [15:0] out_mix(input logic signed [33:0] w,
                                                    input logic signed [15:0] s,
                                                    input logic [15:0] g);
        logic signed [35:0] p;
        p = 36'($signed({1'b0, g}) * s) + 36'(w) + 36'sd16384;
        p = p >>> 15;
        return sat16(p);
    endfunction

    logic out_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            left_out  <= out_mix(lwet_reg, lst_reg, dry_g);
            right_out <= out_mix(rwet_reg, rst_reg, dry_g);
        end
    end

    assign out_valid       = out_valid_reg;
    assign status.out_busy = out_valid_reg && !out_ready;

endmodule

// ===== rtl/core/modulated_feedback_delay.sv =====
// Top level of the stereo modulated feedback delay.
// Depends on mfd_pkg, mfd_if, mfd_ctrl and mfd_datapath.
//
// Stereo flanger-style delay: each input word is written into a 128k-sample
// store per channel, read back at the write pointer minus the base delay plus
// depth times a sine LFO with linear interpolation, fed back and mixed. The
// result word is presented once the sequencer has walked sine ROM read, depth
// multiply, store read, interpolation, feedback write and output mix; the next
// word is taken in the cycle after the result register loads, so a new word is
// not accepted until the last one is through, and later while the output is
// stalled. The stores need no clearing pass: a fill mark makes unwritten
// entries read as zero.
// Configure only while idle.
module modulated_feedback_delay (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0] cfg_data,
    mfd_in_if.sink                         sample_in,
    mfd_out_if.source                      sample_out
);

    mfd_pkg::mfd_cmd_t    cmd;
    mfd_pkg::mfd_status_t status;

    mfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in.valid),
        .in_ready (sample_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    mfd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .left_in   (sample_in.left_in),
        .right_in  (sample_in.right_in),
        .out_valid (sample_out.valid),
        .out_ready (sample_out.ready),
        .left_out  (sample_out.left_out),
        .right_out (sample_out.right_out)
    );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for modulated_feedback_delay: directed and random words
// against a bit-exact predictor. Depends on mfd_pkg, mfd_if and the RTL top level.
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } stereo_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [mfd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mfd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    mfd_in_if  in_ch ();
    mfd_out_if out_ch ();

    modulated_feedback_delay uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (in_ch),
        .sample_out (out_ch)
    );

    always #5 clk = ~clk;

    // predictor state
    logic signed [15:0] left_mem  [mfd_pkg::STORE_DEPTH];
    logic signed [15:0] right_mem [mfd_pkg::STORE_DEPTH];
    longint             sine_lut [mfd_pkg::SINE_TABLE_SIZE+1];
    int unsigned        wr_ptr;
    logic [31:0]        phase_acc;
    int unsigned        m_delay, m_depth;
    logic [31:0]        m_step;
    longint             m_wet, m_fb, m_dry;

    stereo_t     expected_out[$];
    bit          idling = 1'b1;
    int          mismatches = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          idle_cycles = 0;
    int          configs = 0;

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // quarter-wave table from the Q30 odd polynomial
    task automatic fill_sine_lut();
        longint x, x2, acc, v;
        for (int i = 0; i <= mfd_pkg::SINE_TABLE_SIZE; i++)
        begin
            x   = (longint'(i) << 30) / mfd_pkg::SINE_TABLE_SIZE;
            x2  = (x * x) >>> 30;
            acc = 172272;
            acc = -5026995 + ((acc * x2) >>> 30);
            acc = 85569304 + ((acc * x2) >>> 30);
            acc = -693598668 + ((acc * x2) >>> 30);
            acc = 1686629713 + ((acc * x2) >>> 30);
            v   = (((acc * x) >>> 30) + 16384) >>> 15;
            if (v < 0) v = 0;
            if (v > 32768) v = 32768;
            sine_lut[i] = v;
        end
    endtask

    function automatic longint gain_clamp(logic [15:0] g);
        return (g > mfd_pkg::GAIN_UNITY) ? longint'(mfd_pkg::GAIN_UNITY) : longint'(g);
    endfunction

    function automatic longint lfo_sine(logic [31:0] ph);
        int     idx;
        longint v;
        idx = int'(ph[29:20]);
        v = ph[30] ? sine_lut[mfd_pkg::SINE_TABLE_SIZE - idx] : sine_lut[idx];
        return ph[31] ? -v : v;
    endfunction

    // one channel: write, interpolated read, feedback write-back, mix
    function automatic longint mix_channel(ref logic signed [15:0] mem [mfd_pkg::STORE_DEPTH],
                                           input longint din, int unsigned whole,
                                           int unsigned frac);
        longint a, b, delayed, stored, fr;
        fr = longint'(frac);
        mem[wr_ptr] = din[15:0];
        a = mem[whole];
        b = mem[(whole + 1) % mfd_pkg::STORE_DEPTH];
        delayed = (a * (256 - fr) + b * fr + 128) >>> 8;
        stored  = sat16(din + ((m_fb * delayed + 16384) >>> 15));
        mem[wr_ptr] = stored[15:0];
        return sat16((m_wet * delayed + m_dry * stored + 16384) >>> 15);
    endfunction

    function automatic stereo_t predict_flange(logic signed [15:0] l, logic signed [15:0] r);
        int unsigned depth, whole, frac;
        longint      offs, pos, span;
        stereo_t     res;
        depth = (m_depth > m_delay) ? m_delay : m_depth;
        offs  = (longint'(depth) * lfo_sine(phase_acc)) >>> 7;
        span  = longint'(mfd_pkg::STORE_DEPTH) * 256;
        pos   = longint'(wr_ptr) * 256 - longint'(m_delay) * 256 + offs;
        pos   = pos % span;
        if (pos < 0) pos += span;
        whole = 32'(pos / 256);
        frac  = 32'(pos % 256);
        res.left  = 16'(mix_channel(left_mem, longint'(l), whole, frac));
        res.right = 16'(mix_channel(right_mem, longint'(r), whole, frac));
        wr_ptr    = (wr_ptr + 1) % mfd_pkg::STORE_DEPTH;
        phase_acc = phase_acc + m_step;
        return res;
    endfunction

    // wait until nothing is in flight, then let the pipeline settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        wait (expected_out.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(mfd_pkg::cfg_reg_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_config(int unsigned delay, int unsigned depth, logic [31:0] step,
                              logic [15:0] wet, logic [15:0] fb, logic [15:0] dry);
        wait_drained();
        write_reg(mfd_pkg::REG_DELAY, delay & 32'h1FFFF);
        write_reg(mfd_pkg::REG_DEPTH, depth & 32'h1FFFF);
        write_reg(mfd_pkg::REG_STEP, step);
        write_reg(mfd_pkg::REG_WET, {16'd0, wet});
        write_reg(mfd_pkg::REG_FEEDBACK, {16'd0, fb});
        write_reg(mfd_pkg::REG_DRY, {16'd0, dry});
        cfg_we  <= 1'b0;
        m_delay = delay & 32'h1FFFF;
        m_depth = depth & 32'h1FFFF;
        m_step  = step;
        m_wet   = gain_clamp(wet);
        m_fb    = gain_clamp(fb);
        m_dry   = gain_clamp(dry);
        configs++;
    endtask

    // send one word; valid stays high after acceptance for back-to-back words
    task automatic send_word(logic signed [15:0] l, logic signed [15:0] r);
        if (idling && $urandom_range(99) < 13)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.left_in  <= l;
        in_ch.right_in <= r;
        do @(posedge clk); while (!in_ch.ready);
        expected_out.push_back(predict_flange(l, r));
        words_in++;
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(3) == 0)
                send_word(16'(int'($urandom_range(4095)) - 2048),
                          16'(int'($urandom_range(4095)) - 2048));
            else
                send_word(16'($urandom()), 16'($urandom()));
        end
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        stereo_t exp_w;
        if (out_ch.valid && out_ch.ready)
        begin
            words_out++;
            if (expected_out.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected word L=%0d R=%0d",
                             out_ch.left_out, out_ch.right_out);
            end
            else
            begin
                exp_w = expected_out.pop_front();
                if (out_ch.left_out !== exp_w.left || out_ch.right_out !== exp_w.right)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word %0d expected L=%0d R=%0d got L=%0d R=%0d",
                                 words_out, exp_w.left, exp_w.right,
                                 out_ch.left_out, out_ch.right_out);
                end
            end
        end
        out_ch.ready <= !(idling && $urandom_range(99) < 13);
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // zero delay with wet at unity returns the current input
    task automatic test_zero_delay();
        set_config(0, 0, 0, mfd_pkg::GAIN_UNITY, 0, 0);
        send_word(16'sh7FFF, -16'sh8000);
        send_word(-16'sh8000, 16'sh7FFF);
        send_word(0, -1);
        send_word(16'sh5555, -16'sh5556);
    endtask

    // gains above unity saturate; full feedback overflows the stored sum
    task automatic test_gain_overflow();
        set_config(1, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (3) send_word(16'sh7FFF, -16'sh8000);
        send_word(-16'sh8000, 16'sh7FFF);
        send_word(16'sh7FFF, 16'sh7FFF);
    endtask

    // depth larger than the delay is clamped, LFO at a quarter turn per word
    task automatic test_depth_clamp();
        set_config(4, 17'h1FFFF, 32'h4000_0000, 16'h4000, 16'h2000, 16'h4000);
        for (int i = 0; i < 8; i++)
            send_word(16'(i * 4000 - 16000), 16'(16000 - i * 3000));
    endtask

    // longest delay wraps the read address around the store
    task automatic test_store_wrap();
        set_config(17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, mfd_pkg::GAIN_UNITY,
                   mfd_pkg::GAIN_UNITY, 16'h0001);
        send_word(16'sh1234, -16'sh1234);
        send_word(-1, 1);
        send_word(16'sh7FFF, -16'sh8000);
    endtask

    // random settings, mostly short delays so feedback and modulation matter
    task automatic test_random_phases();
        int unsigned d, dp;
        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(9))
                0:       d = $urandom_range(17'h1FFFF);
                1, 2:    d = $urandom_range(2000);
                default: d = $urandom_range(64);
            endcase
            dp = $urandom_range(d + 8);
            set_config(d, dp, ($urandom_range(1)) ? $urandom() : $urandom_range(1 << 26),
                       $urandom_range(1) ? 16'($urandom_range(32768)) : 16'($urandom()),
                       $urandom_range(1) ? 16'($urandom_range(32768)) : 16'($urandom()),
                       $urandom_range(1) ? 16'($urandom_range(32768)) : 16'($urandom()));
            idling = (ph != 3);
            send_random(50);
            // sender holds off until every result is back
            if (ph == 5)
                wait_drained();
            send_random(50);
        end
        idling = 1'b1;
    endtask

    initial
    begin
        in_ch.valid    = 1'b0;
        in_ch.left_in  = '0;
        in_ch.right_in = '0;
        out_ch.ready   = 1'b0;
        fill_sine_lut();
        for (int i = 0; i < mfd_pkg::STORE_DEPTH; i++)
        begin
            left_mem[i]  = '0;
            right_mem[i] = '0;
        end
        wr_ptr = 0;
        phase_acc = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_delay();
        test_gain_overflow();
        test_depth_clamp();
        test_store_wrap();
        test_random_phases();

        wait_drained();
        $display("Covered %0d words in, %0d out, over %0d register settings",
                 words_in, words_out, configs);
        $display("Zero delay, gain saturation, depth clamp, store wrap and random mixes");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
